// ===== rtl/aigps_pkg.sv =====
// aigps_pkg: shared types and constants for the and-inverter graph simulator
// depends on: nothing
package aigps_pkg;

  localparam int LIT_W     = 14;
  localparam int IDX_W     = 12;
  localparam int WORD_W    = 64;
  localparam int OIDX_W    = 6;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  // wide enough for every count, index and literal variable at the default parameter values
  localparam int CALC_W    = 18;

  localparam logic [LIT_W-1:0] LIT_TRUE = LIT_W'(1);

  typedef enum logic [1:0] {
    OP_LOAD_AND = 2'd0,
    OP_LOAD_OUT = 2'd1,
    OP_LOAD_IN  = 2'd2,
    OP_EVAL     = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_AND_COUNT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = CFG_IDX_W'(2);

  typedef struct packed {
    op_t               operation;
    logic [IDX_W-1:0]  entry_index;
    logic [LIT_W-1:0]  literal_a;
    logic [LIT_W-1:0]  literal_b;
    logic [WORD_W-1:0] pattern_word;
  } in_item_t;

  typedef struct packed {
    logic [OIDX_W-1:0] output_index;
    logic [WORD_W-1:0] output_word;
    logic              last_output;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              ld_en;
    logic              issue;
    logic              is_out;
    logic              last;
    logic [CALC_W-1:0] idx;
  } aigps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              adv;
    logic              busy;
    logic [CALC_W-1:0] na_eff;
    logic [6:0]        no_eff;
  } aigps_status_t;

endpackage

// ===== rtl/aigps_ctrl.sv =====
// aigps_ctrl: sequencer that steps through and nodes and then outputs
// depends on: aigps_pkg
module aigps_ctrl
  import aigps_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  op_t           in_op,
  input  aigps_status_t status,
  output aigps_cmd_t    cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_NODES, ST_OUTS, ST_DRAIN} state_t;

  state_t            state_r, state_nxt;
  logic [CALC_W-1:0] cnt_r, cnt_nxt;
  logic [CALC_W-1:0] cnt_inc;
  logic [CALC_W-1:0] no_ext;
  logic              accept;

  assign cnt_inc  = cnt_r + CALC_W'(1);
  assign no_ext   = CALC_W'(status.no_eff);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.ld_en  = accept && (in_op != OP_EVAL);
    cmd.issue  = (state_r == ST_NODES) || (state_r == ST_OUTS);
    cmd.is_out = (state_r == ST_OUTS);
    cmd.last   = (state_r == ST_OUTS) && (cnt_inc == no_ext);
    cmd.idx    = cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && (in_op == OP_EVAL)) begin
          if (status.na_eff != '0)      state_nxt = ST_NODES;
          else if (status.no_eff != '0) state_nxt = ST_OUTS;
          else                          state_nxt = ST_DRAIN;
        end
      end
      ST_NODES: begin
        if (status.adv) begin
          if (cnt_inc == status.na_eff) begin
            cnt_nxt   = '0;
            state_nxt = (status.no_eff != '0) ? ST_OUTS : ST_DRAIN;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      ST_OUTS: begin
        if (status.adv) begin
          if (cnt_inc == no_ext) begin
            cnt_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      ST_DRAIN: begin
        if (!status.busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/aigps_datapath.sv =====
// aigps_datapath: graph stores, node pipeline (stage 1 and stage 2) and output register
// depends on: aigps_pkg
module aigps_datapath
  import aigps_pkg::*;
#(
  parameter int MAX_INPUTS  = 256,
  parameter int MAX_ANDS    = 4096,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_item_t             in_item,
  input  aigps_cmd_t           cmd,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_item_t            out_item,
  output aigps_status_t        status
);

  localparam int AW = (MAX_ANDS > 1) ? $clog2(MAX_ANDS) : 1;
  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  typedef enum logic [1:0] {LC_ZERO, LC_INPUT, LC_NODE} lit_cls_t;

  typedef struct packed {
    lit_cls_t          cls;
    logic              inv;
    logic [CALC_W-1:0] in_addr;
    logic [CALC_W-1:0] node_addr;
  } lit_dec_t;

  // configuration
  logic [8:0]        input_count_r;
  logic [CFG_W-1:0]  and_count_r;
  logic [6:0]        output_count_r;
  logic [CALC_W-1:0] ni_eff, na_eff;
  logic [6:0]        no_eff;

  // stores
  logic [2*LIT_W-1:0] and_mem  [MAX_ANDS];
  logic [LIT_W-1:0]   olit_mem [MAX_OUTPUTS];
  logic [WORD_W-1:0]  in_mem   [MAX_INPUTS];
  logic [WORD_W-1:0]  node_mem [MAX_ANDS];
  logic [MAX_INPUTS-1:0] in_vld_r;

  logic [CALC_W-1:0] ent;
  logic              adv;

  // stage 1
  logic              s1_v_r;
  logic              s1_out_r, s1_last_r;
  logic [CALC_W-1:0] s1_idx_r;
  logic [2*LIT_W-1:0] ch_rd_r;
  logic [LIT_W-1:0]  ol_rd_r;
  logic [LIT_W-1:0]  lit_a, lit_b;
  lit_dec_t          dec_a, dec_b;

  // stage 2
  logic              s2_v_r;
  logic              s2_out_r, s2_last_r;
  logic [CALC_W-1:0] s2_idx_r;
  lit_cls_t          s2_cls_a_r, s2_cls_b_r;
  logic              s2_inv_a_r, s2_inv_b_r;
  logic [AW-1:0]     s2_na_a_r, s2_na_b_r;
  logic [WORD_W-1:0] rin_a_r, rin_b_r, rn_a_r, rn_b_r;
  logic              vin_a_r, vin_b_r;
  logic [WORD_W-1:0] word_a, word_b, res;

  // last node write, for a child that reads the node just before it
  logic              byp_v_r;
  logic [AW-1:0]     byp_addr_r;
  logic [WORD_W-1:0] byp_word_r;

  logic              out_valid_r;
  out_item_t         out_r;

  function automatic lit_dec_t lit_decode(input logic [LIT_W-1:0] lit,
                                          input logic [CALC_W-1:0] ni,
                                          input logic [CALC_W-1:0] na);
    lit_dec_t          d;
    logic [CALC_W-1:0] v;
    logic [CALC_W-1:0] diff;
    v           = CALC_W'(lit[LIT_W-1:1]);
    diff        = v - ni - CALC_W'(1);
    d.inv       = lit[0];
    d.in_addr   = v - CALC_W'(1);
    d.node_addr = diff;
    if (v == '0)        d.cls = LC_ZERO;
    else if (v <= ni)   d.cls = LC_INPUT;
    else if (diff < na) d.cls = LC_NODE;
    else                d.cls = LC_ZERO;
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] word_sel(input lit_cls_t cls,
                                                 input logic inv,
                                                 input logic [WORD_W-1:0] rin,
                                                 input logic vin,
                                                 input logic [WORD_W-1:0] rn,
                                                 input logic hit,
                                                 input logic [WORD_W-1:0] byp);
    logic [WORD_W-1:0] w;
    case (cls)
      LC_INPUT: w = vin ? rin : '0;
      LC_NODE:  w = hit ? byp : rn;
      default:  w = '0;
    endcase
    return inv ? ~w : w;
  endfunction

  // configuration registers and saturated counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r  <= '0;
      and_count_r    <= '0;
      output_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT:  input_count_r  <= cfg_data[8:0];
        CFG_AND_COUNT:    and_count_r    <= cfg_data;
        CFG_OUTPUT_COUNT: output_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign ni_eff = (CALC_W'(input_count_r) > CALC_W'(MAX_INPUTS)) ?
                  CALC_W'(MAX_INPUTS) : CALC_W'(input_count_r);
  assign na_eff = (CALC_W'(and_count_r) > CALC_W'(MAX_ANDS)) ?
                  CALC_W'(MAX_ANDS) : CALC_W'(and_count_r);
  assign no_eff = (output_count_r > 7'(MAX_OUTPUTS)) ? 7'(MAX_OUTPUTS) : output_count_r;

  assign ent = CALC_W'(in_item.entry_index);
  assign adv = !out_valid_r || !out_stall;

  // and node children: written by loads, read at issue
  always_ff @(posedge clk) begin
    if (cmd.ld_en && (in_item.operation == OP_LOAD_AND) && (ent < CALC_W'(MAX_ANDS)))
      and_mem[ent[AW-1:0]] <= {in_item.literal_a, in_item.literal_b};
    if (adv && cmd.issue && !cmd.is_out)
      ch_rd_r <= and_mem[cmd.idx[AW-1:0]];
  end

  // output literals
  always_ff @(posedge clk) begin
    if (cmd.ld_en && (in_item.operation == OP_LOAD_OUT) && (ent < CALC_W'(MAX_OUTPUTS)))
      olit_mem[ent[OW-1:0]] <= in_item.literal_a;
    if (adv && cmd.issue && cmd.is_out)
      ol_rd_r <= olit_mem[cmd.idx[OW-1:0]];
  end

  // stage 1: literal decode and word reads
  assign lit_a = s1_out_r ? ol_rd_r : ch_rd_r[2*LIT_W-1:LIT_W];
  assign lit_b = s1_out_r ? LIT_TRUE : ch_rd_r[LIT_W-1:0];
  assign dec_a = lit_decode(lit_a, ni_eff, na_eff);
  assign dec_b = lit_decode(lit_b, ni_eff, na_eff);

  // primary input words, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= '0;
    end else if (cmd.ld_en && (in_item.operation == OP_LOAD_IN) &&
                 (ent < CALC_W'(MAX_INPUTS))) begin
      in_vld_r[ent[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en && (in_item.operation == OP_LOAD_IN) && (ent < CALC_W'(MAX_INPUTS)))
      in_mem[ent[IW-1:0]] <= in_item.pattern_word;
    if (adv) begin
      rin_a_r <= in_mem[dec_a.in_addr[IW-1:0]];
      rin_b_r <= in_mem[dec_b.in_addr[IW-1:0]];
      vin_a_r <= in_vld_r[dec_a.in_addr[IW-1:0]];
      vin_b_r <= in_vld_r[dec_b.in_addr[IW-1:0]];
    end
  end

  // node words: written from stage 2, read from stage 1
  always_ff @(posedge clk) begin
    if (adv && s2_v_r && !s2_out_r)
      node_mem[s2_idx_r[AW-1:0]] <= res;
    if (adv) begin
      rn_a_r <= node_mem[dec_a.node_addr[AW-1:0]];
      rn_b_r <= node_mem[dec_b.node_addr[AW-1:0]];
    end
  end

  // pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      byp_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= cmd.issue;
      s2_v_r  <= s1_v_r;
      byp_v_r <= s2_v_r && !s2_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_out_r   <= cmd.is_out;
      s1_last_r  <= cmd.last;
      s1_idx_r   <= cmd.idx;
      s2_out_r   <= s1_out_r;
      s2_last_r  <= s1_last_r;
      s2_idx_r   <= s1_idx_r;
      s2_cls_a_r <= dec_a.cls;
      s2_cls_b_r <= dec_b.cls;
      s2_inv_a_r <= dec_a.inv;
      s2_inv_b_r <= dec_b.inv;
      s2_na_a_r  <= dec_a.node_addr[AW-1:0];
      s2_na_b_r  <= dec_b.node_addr[AW-1:0];
      byp_addr_r <= s2_idx_r[AW-1:0];
      byp_word_r <= res;
    end
  end

  // stage 2: select, invert, and
  assign word_a = word_sel(s2_cls_a_r, s2_inv_a_r, rin_a_r, vin_a_r, rn_a_r,
                           byp_v_r && (byp_addr_r == s2_na_a_r), byp_word_r);
  assign word_b = word_sel(s2_cls_b_r, s2_inv_b_r, rin_b_r, vin_b_r, rn_b_r,
                           byp_v_r && (byp_addr_r == s2_na_b_r), byp_word_r);
  assign res    = word_a & word_b;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r && s2_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r && s2_out_r) begin
      out_r.output_index <= OIDX_W'(s2_idx_r);
      out_r.output_word  <= res;
      out_r.last_output  <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    status.adv    = adv;
    status.busy   = s1_v_r || s2_v_r;
    status.na_eff = na_eff;
    status.no_eff = no_eff;
  end

endmodule

// ===== rtl/and_inverter_graph_parallel_simulator.sv =====
// and_inverter_graph_parallel_simulator: top level, 64-pattern aig simulator
// load items are taken back to back; evaluate issues all and nodes, then all outputs,
// into the node pipeline, one node or output word per cycle unless the output stalls,
// a rate set by the single issue slot of the node pipeline
// output stalls hold the whole pipeline; the next item is taken once it has drained
// synchronous active-low reset clears counts, input word valid bits and all control state
module and_inverter_graph_parallel_simulator
  import aigps_pkg::*;
#(
  parameter int MAX_INPUTS  = 256,
  parameter int MAX_ANDS    = 4096,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  aigps_cmd_t    cmd;
  aigps_status_t status;

  // controller: walks and nodes then outputs, holds off items while busy
  aigps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_item.operation),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: stores, node pipeline with one-deep bypass, output register
  aigps_datapath #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_ANDS    (MAX_ANDS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .status    (status)
  );

endmodule

// ===== rtl/aigps_checker.sv =====
// aigps_checker: port-level assertions for the aig simulator, bound to the top level
// depends on: aigps_pkg, and_inverter_graph_parallel_simulator
module aigps_checker
  import aigps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic [OIDX_W-1:0] exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_idx_r <= out_item.last_output ? '0 : out_item.output_index + OIDX_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.output_index == exp_idx_r)
    else $error("output index out of sequence");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.operation == OP_EVAL) |=> in_stall)
    else $error("input not held off after evaluate");

  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("output item appeared while idle");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind and_inverter_graph_parallel_simulator aigps_checker u_aigps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
